// ===== hdl/tnq_pkg.sv =====
`default_nettype none
package tnq_pkg;

  localparam int QUEUE_SLOTS = 64;
  localparam int PTR_W       = $clog2(QUEUE_SLOTS);
  localparam int FREQ_W      = 16;
  localparam int DUR_W       = 16;
  localparam int TICKS_W     = 17;
  localparam int DIVISOR_W   = 16;

  // Timer input clock in Hz; the quotient needs all of its bits.
  localparam int PIT_W = 21;
  localparam logic [PIT_W-1:0] PIT_CLOCK = PIT_W'(1193180);

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

  localparam logic REQ_OFFER = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [1:0] {
    TONE_NONE    = 2'd0,
    TONE_PROGRAM = 2'd1,
    TONE_OFF     = 2'd2
  } tone_action_t;

  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [TICKS_W-1:0] ticks;
  } note_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tnq_channels.sv =====
`default_nettype none
interface tnq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [tnq_pkg::FREQ_W-1:0] note_frequency;
  logic [tnq_pkg::DUR_W-1:0]  note_duration;

  modport source (output valid, output req_type, output note_frequency,
                  output note_duration, input ready);
  modport sink   (input valid, input req_type, input note_frequency,
                  input note_duration, output ready);
endinterface

interface tnq_res_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [1:0]                    tone_action;
  logic [tnq_pkg::DIVISOR_W-1:0] divisor;
  logic                          queue_empty;
  logic                          queue_full;

  modport source (output valid, output accepted, output tone_action, output divisor,
                  output queue_empty, output queue_full, input ready);
  modport sink   (input valid, input accepted, input tone_action, input divisor,
                  input queue_empty, input queue_full, output ready);
endinterface
`default_nettype wire

// ===== hdl/tone_note_queue_player.sv =====
`default_nettype none
// Note queue player for a tone timer. An offer transaction stores a note (frequency and
// duration) unless the queue is full. A tick transaction on a nonempty queue reads the
// head note, then divides the 1193180 Hz timer clock by its frequency in a serial
// restoring divider, one quotient bit per cycle; a tick passes through acceptance, note
// read, 21 divider steps and result load, or only acceptance, note read and result
// load for a silent note. The queue holds QUEUE_SLOTS-1 notes in a dual-port RAM.
// Results sit in an output register, so the next request may be taken in the cycle
// the previous result is consumed.
module tone_note_queue_player (
  input wire logic  clk,
  input wire logic  rst,
  tnq_req_if.sink   req,
  tnq_res_if.source res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV
  } state_t;

  state_t state;

  logic [tnq_pkg::PTR_W-1:0] read_pointer;
  logic [tnq_pkg::PTR_W-1:0] write_pointer;
  logic [tnq_pkg::PTR_W-1:0] read_pointer_next;
  logic [tnq_pkg::PTR_W-1:0] write_pointer_next;

  logic           mem_we;
  logic [tnq_pkg::PTR_W-1:0] mem_waddr;
  tnq_pkg::note_t mem_wdata;
  tnq_pkg::note_t head;

  logic [tnq_pkg::TICKS_W-1:0]   ticks_dec;
  logic                          div_start;
  logic                          div_done;
  logic [tnq_pkg::DIVISOR_W-1:0] div_quotient;

  logic accept;
  logic is_empty;
  logic is_full;
  logic empty_next;
  logic full_next;
  logic res_load;

  assign req.ready = (state == ST_IDLE) && (!res.valid || res.ready);
  assign accept    = req.valid && req.ready;

  assign is_empty   = (read_pointer == write_pointer);
  assign is_full    = (tnq_pkg::next_ptr(write_pointer) == read_pointer);
  assign empty_next = (read_pointer_next == write_pointer_next);
  assign full_next  = (tnq_pkg::next_ptr(write_pointer_next) == read_pointer_next);

  assign ticks_dec = head.ticks - tnq_pkg::TICKS_W'(1);
  assign div_start = (state == ST_START) && (head.freq != '0);

  // A new result is loaded in this cycle; it takes priority over draining the old one.
  assign res_load = ((state == ST_IDLE) && accept &&
                     !(req.req_type == tnq_pkg::REQ_TICK && !is_empty)) ||
                    ((state == ST_START) && (head.freq == '0)) ||
                    ((state == ST_DIV) && div_done);

  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    mem_we             = 1'b0;
    mem_waddr          = write_pointer;
    mem_wdata.freq     = req.note_frequency;
    mem_wdata.ticks    = {1'b0, req.note_duration} + tnq_pkg::TICKS_W'(1);
    if (state == ST_IDLE) begin
      if (accept && req.req_type == tnq_pkg::REQ_OFFER && !is_full) begin
        mem_we             = 1'b1;
        write_pointer_next = tnq_pkg::next_ptr(write_pointer);
      end
    end else if (state == ST_START) begin
      // Write back the decremented count; the note leaves when it reaches zero.
      mem_we          = 1'b1;
      mem_waddr       = read_pointer;
      mem_wdata.freq  = head.freq;
      mem_wdata.ticks = ticks_dec;
      if (ticks_dec == '0) begin
        read_pointer_next = tnq_pkg::next_ptr(read_pointer);
      end
    end
  end

  tnq_note_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (read_pointer),
    .rdata (head)
  );

  tnq_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (head.freq),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      read_pointer  <= '0;
      write_pointer <= '0;
      res.valid     <= 1'b0;
    end else begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      if (res.valid && res.ready && !res_load) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.req_type == tnq_pkg::REQ_TICK && !is_empty) begin
              state <= ST_START;
            end else begin
              res.valid       <= 1'b1;
              res.accepted    <= (req.req_type == tnq_pkg::REQ_OFFER) && !is_full;
              res.tone_action <= tnq_pkg::TONE_NONE;
              res.divisor     <= '0;
              res.queue_empty <= empty_next;
              res.queue_full  <= full_next;
            end
          end
        end
        ST_START: begin
          if (head.freq == '0) begin
            state           <= ST_IDLE;
            res.valid       <= 1'b1;
            res.accepted    <= 1'b0;
            res.tone_action <= tnq_pkg::TONE_OFF;
            res.divisor     <= '0;
            res.queue_empty <= empty_next;
            res.queue_full  <= full_next;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state           <= ST_IDLE;
            res.valid       <= 1'b1;
            res.accepted    <= 1'b0;
            res.tone_action <= tnq_pkg::TONE_PROGRAM;
            res.divisor     <= div_quotient;
            res.queue_empty <= is_empty;
            res.queue_full  <= is_full;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_tick_starts_read: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == tnq_pkg::REQ_TICK && !is_empty |=> state == ST_START)
    else $error("tick on a nonempty queue did not start a note read");

  a_accept_no_tone: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.accepted |-> res.tone_action == tnq_pkg::TONE_NONE)
    else $error("accepted offer carries a tone action");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.queue_empty && res.queue_full))
    else $error("queue reported both empty and full");

  a_divisor_only_on_program: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.tone_action != tnq_pkg::TONE_PROGRAM |-> res.divisor == '0)
    else $error("divisor set without a program action");

  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && !div_done |=> !$rose(res.valid))
    else $error("result appeared before the division finished");

endmodule
`default_nettype wire

// ===== hdl/tnq_note_ram.sv =====
`default_nettype none
module tnq_note_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [tnq_pkg::PTR_W-1:0] waddr,
  input  wire tnq_pkg::note_t            wdata,
  input  wire logic [tnq_pkg::PTR_W-1:0] raddr,
  output tnq_pkg::note_t                 rdata
);

  tnq_pkg::note_t mem [tnq_pkg::QUEUE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/tnq_divider.sv =====
`default_nettype none
// Restoring divider of the timer clock by a 16-bit frequency, one quotient bit a cycle.
module tnq_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [tnq_pkg::FREQ_W-1:0]    divisor,
  output logic                               done,
  output logic [tnq_pkg::DIVISOR_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(tnq_pkg::PIT_W + 1);

  logic [tnq_pkg::PIT_W-1:0]  dvd;
  logic [tnq_pkg::PIT_W-1:0]  quo;
  logic [tnq_pkg::FREQ_W-1:0] rem;
  logic [tnq_pkg::FREQ_W-1:0] dsr;
  logic [CNT_W-1:0]           count;
  logic                       busy;

  logic [tnq_pkg::FREQ_W:0] trial;
  logic [tnq_pkg::FREQ_W:0] diff;
  logic                     fits;

  always_comb begin
    trial = {rem, dvd[tnq_pkg::PIT_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = (trial >= {1'b0, dsr});
  end

  assign quotient = quo[tnq_pkg::DIVISOR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(tnq_pkg::PIT_W);
        dvd   <= tnq_pkg::PIT_CLOCK;
        quo   <= '0;
        rem   <= '0;
        dsr   <= divisor;
      end else if (busy) begin
        // The remainder stays below the divisor, so 16 bits always hold it.
        dvd   <= {dvd[tnq_pkg::PIT_W-2:0], 1'b0};
        quo   <= {quo[tnq_pkg::PIT_W-2:0], fits};
        rem   <= fits ? diff[tnq_pkg::FREQ_W-1:0] : trial[tnq_pkg::FREQ_W-1:0];
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_tone_note_queue_player.sv =====
module tb_tone_note_queue_player;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                          accepted;
    tnq_pkg::tone_action_t         action;
    logic [tnq_pkg::DIVISOR_W-1:0] divisor;
    logic                          empty;
    logic                          full;
  } tone_result_t;

  logic clk;
  logic rst;

  tnq_req_if req_if ();
  tnq_res_if res_if ();

  tone_note_queue_player dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .res (res_if.source)
  );

  // Shadow copy of the note queue.
  logic [tnq_pkg::FREQ_W-1:0]  shadow_freq [tnq_pkg::QUEUE_SLOTS];
  logic [tnq_pkg::TICKS_W-1:0] shadow_ticks [tnq_pkg::QUEUE_SLOTS];
  logic [tnq_pkg::PTR_W-1:0]   head_idx;
  logic [tnq_pkg::PTR_W-1:0]   tail_idx;

  tone_result_t tone_results_due [$];

  int mismatches;
  int src_idle_pct;
  int sink_idle_pct;
  int sink_hold_cycles;
  int stall_cycles;

  int notes_stored;
  int notes_rejected;
  int tones_programmed;
  int tones_silenced;
  int ticks_on_empty;
  int times_full;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    req_if.valid          = 1'b0;
    req_if.req_type       = tnq_pkg::REQ_OFFER;
    req_if.note_frequency = '0;
    req_if.note_duration  = '0;
    res_if.ready          = 1'b0;
  end

  function automatic logic [tnq_pkg::PTR_W-1:0] slot_after(
      input logic [tnq_pkg::PTR_W-1:0] p);
    return (int'(p) == tnq_pkg::QUEUE_SLOTS - 1) ? '0 : p + tnq_pkg::PTR_W'(1);
  endfunction

  function automatic logic queue_holds_none();
    return head_idx == tail_idx;
  endfunction

  function automatic logic queue_at_capacity();
    return slot_after(tail_idx) == head_idx;
  endfunction

  // Applies one accepted request to the shadow queue and records the result it must give.
  task automatic play_queue_step(input logic kind, input logic [tnq_pkg::FREQ_W-1:0] freq,
                                 input logic [tnq_pkg::DUR_W-1:0] dur);
    tone_result_t r;
    logic [tnq_pkg::TICKS_W-1:0] left;
    int f;
    r = '0;
    r.action = tnq_pkg::TONE_NONE;
    if (kind == tnq_pkg::REQ_OFFER) begin
      if (!queue_at_capacity()) begin
        shadow_ticks[tail_idx] = tnq_pkg::TICKS_W'(dur) + tnq_pkg::TICKS_W'(1);
        shadow_freq[tail_idx]  = freq;
        tail_idx = slot_after(tail_idx);
        r.accepted = 1'b1;
        notes_stored++;
      end else begin
        notes_rejected++;
      end
    end else if (!queue_holds_none()) begin
      f = int'(shadow_freq[head_idx]);
      if (f != 0) begin
        r.divisor = tnq_pkg::DIVISOR_W'(int'(tnq_pkg::PIT_CLOCK) / f);
        r.action  = tnq_pkg::TONE_PROGRAM;
        tones_programmed++;
      end else begin
        r.action = tnq_pkg::TONE_OFF;
        tones_silenced++;
      end
      left = shadow_ticks[head_idx] - tnq_pkg::TICKS_W'(1);
      shadow_ticks[head_idx] = left;
      if (left == '0) head_idx = slot_after(head_idx);
    end else begin
      ticks_on_empty++;
    end
    r.empty = queue_holds_none();
    r.full  = queue_at_capacity();
    if (r.full) times_full++;
    tone_results_due.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Valid is left high after a transaction; the next call or go_quiet decides at the
  // following falling edge, so valid is never lowered and raised in one step.
  task automatic send_request(input logic kind, input logic [tnq_pkg::FREQ_W-1:0] freq,
                              input logic [tnq_pkg::DUR_W-1:0] dur);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.req_type       <= kind;
    req_if.note_frequency <= freq;
    req_if.note_duration  <= dur;
    do @(posedge clk); while (!req_if.ready);
    play_queue_step(kind, freq, dur);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    req_if.valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    go_quiet();
    while (tone_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  function automatic logic [tnq_pkg::FREQ_W-1:0] pick_freq();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return tnq_pkg::FREQ_W'($urandom_range(18, 1));
    return tnq_pkg::FREQ_W'($urandom);
  endfunction

  function automatic logic [tnq_pkg::DUR_W-1:0] pick_dur();
    if ($urandom_range(99) < 70) return '0;
    return tnq_pkg::DUR_W'($urandom_range(3, 1));
  endfunction

  task automatic send_tick();
    send_request(tnq_pkg::REQ_TICK, tnq_pkg::FREQ_W'($urandom), tnq_pkg::DUR_W'($urandom));
  endtask

  task automatic tick_until_empty();
    while (!queue_holds_none()) send_tick();
  endtask

  task automatic test_ticks_on_empty();
    send_request(tnq_pkg::REQ_TICK, '1, '1);
    send_request(tnq_pkg::REQ_TICK, '0, '0);
  endtask

  // Quotients above 16 bits for the lowest frequencies, the smallest quotient, silence.
  task automatic test_tone_extremes();
    send_request(tnq_pkg::REQ_OFFER, 16'd1, 16'd0);
    send_request(tnq_pkg::REQ_OFFER, 16'd18, 16'd0);
    send_request(tnq_pkg::REQ_OFFER, 16'd19, 16'd0);
    send_request(tnq_pkg::REQ_OFFER, 16'hFFFF, 16'd0);
    send_request(tnq_pkg::REQ_OFFER, 16'd0, 16'd1);
    send_request(tnq_pkg::REQ_OFFER, 16'd1193, 16'd2);
    tick_until_empty();
  endtask

  task automatic test_fill_to_full();
    while (!queue_at_capacity()) send_request(tnq_pkg::REQ_OFFER, pick_freq(), pick_dur());
    send_request(tnq_pkg::REQ_OFFER, '1, '1);
    send_request(tnq_pkg::REQ_OFFER, '0, '0);
    send_tick();
    send_request(tnq_pkg::REQ_OFFER, pick_freq(), '0);
    tick_until_empty();
  endtask

  // The receiver refuses results for a long stretch while offers keep coming, so the
  // output register fills and the request side has to stall.
  task automatic test_output_backpressure();
    sink_hold_cycles = 300;
    repeat (10) send_request(tnq_pkg::REQ_OFFER, pick_freq(), pick_dur());
    wait_all_results();
  endtask

  task automatic run_random_traffic(input int n_items);
    int offer_pct;
    for (int i = 0; i < n_items; i++) begin
      // Alternate filling and draining stretches so the queue swings between its limits.
      offer_pct = ((i / 60) % 2 == 0) ? 85 : 25;
      if ($urandom_range(99) < offer_pct)
        send_request(tnq_pkg::REQ_OFFER, pick_freq(), pick_dur());
      else
        send_tick();
    end
  endtask

  // Long notes are left at the head; only a few of their ticks are played.
  task automatic test_long_notes();
    tick_until_empty();
    send_request(tnq_pkg::REQ_OFFER, tnq_pkg::FREQ_W'($urandom), 16'hFFFF);
    send_request(tnq_pkg::REQ_OFFER, tnq_pkg::FREQ_W'($urandom),
                 tnq_pkg::DUR_W'($urandom) | 16'h8000);
    send_request(tnq_pkg::REQ_OFFER, '0, tnq_pkg::DUR_W'($urandom));
    repeat (3) send_tick();
  endtask

  always @(negedge clk) begin
    if (sink_hold_cycles > 0) begin
      res_if.ready <= 1'b0;
      sink_hold_cycles <= sink_hold_cycles - 1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    tone_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (tone_results_due.size() == 0) begin
        report_mismatch("result transaction with no request outstanding");
      end else begin
        want = tone_results_due.pop_front();
        if (res_if.accepted !== want.accepted)
          report_mismatch($sformatf("accepted %b, predicted %b", res_if.accepted,
                                    want.accepted));
        if (res_if.tone_action !== want.action)
          report_mismatch($sformatf("tone_action %0d, predicted %0d", res_if.tone_action,
                                    want.action));
        if (res_if.divisor !== want.divisor)
          report_mismatch($sformatf("divisor %0d, predicted %0d", res_if.divisor,
                                    want.divisor));
        if (res_if.queue_empty !== want.empty)
          report_mismatch($sformatf("queue_empty %b, predicted %b", res_if.queue_empty,
                                    want.empty));
        if (res_if.queue_full !== want.full)
          report_mismatch($sformatf("queue_full %b, predicted %b", res_if.queue_full,
                                    want.full));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("tone_note_queue_player test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    mismatches       = 0;
    sink_hold_cycles = 0;
    stall_cycles     = 0;
    notes_stored     = 0;
    notes_rejected   = 0;
    tones_programmed = 0;
    tones_silenced   = 0;
    ticks_on_empty   = 0;
    times_full       = 0;
    head_idx         = '0;
    tail_idx         = '0;
    set_idling(33, 76);
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_ticks_on_empty();
    test_tone_extremes();
    test_fill_to_full();
    wait_all_results();
    run_random_traffic(70);
    wait_all_results();

    set_idling(76, 33);
    test_output_backpressure();
    run_random_traffic(70);
    wait_all_results();

    set_idling(0, 0);
    run_random_traffic(70);
    test_long_notes();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tone_results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", tone_results_due.size()));

    $display("Covered: %0d notes stored, %0d refused on a full queue (%0d full states seen)",
             notes_stored, notes_rejected, times_full);
    $display("Ticks: %0d programmed a tone, %0d silenced, %0d on an empty queue",
             tones_programmed, tones_silenced, ticks_on_empty);
    if (mismatches == 0)
      $display("tone_note_queue_player test passed");
    else
      $display("tone_note_queue_player test failed");
    $finish;
  end

endmodule
